### rtl/tgti_pkg.sv
// ----------------------------------------------------------------------------
// tgti_pkg: shared types and tables of the terrain grid triangle indexer
// Holds the patch descriptor that runs from the front end to the back end,
// the register and request codes, and the triangle shape tables.
// ----------------------------------------------------------------------------
`default_nettype none

package tgti_pkg;

	// Width of an intermediate vertex index (row * width + column fits)
	localparam int IDX_W   = 18;
	// Width of a patch origin coordinate (127 * 4)
	localparam int ORG_W   = 9;
	// Width of the configuration register index
	localparam int CFG_IDX_W = 2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;

	// Request kinds
	localparam logic REQ_FINE   = 1'b0;
	localparam logic REQ_COARSE = 1'b1;

	// Segment of the last triangle group in a patch
	localparam logic [2:0] SEG_LAST = 3'd7;

	// One triangle as three (column, row) offsets from the patch origin
	typedef struct packed {
		logic [2:0] ac;
		logic [2:0] ar;
		logic [2:0] bc;
		logic [2:0] br;
		logic [2:0] cc;
		logic [2:0] cr;
	} tri_t;

	// Classified patch, queued between front and back end
	typedef struct packed {
		logic             coarse;
		logic             in_range;
		logic             top;
		logic             left;
		logic             right;
		logic             bottom;
		logic [IDX_W-1:0] base;
	} patch_desc_t;

	// Triangle shape for a segment; a split segment gives two triangles
	function automatic tri_t tri_shape(input logic coarse, input logic [2:0] seg,
		input logic split, input logic sub);
		logic [5:0] key;
		tri_t       shape;
		key = coarse ? {1'b1, split, sub, seg} : {3'b000, seg};
		unique case (key)
			// fine 2x2 patch
			6'b000_000: shape = {3'd0, 3'd0, 3'd1, 3'd0, 3'd1, 3'd1};
			6'b000_001: shape = {3'd0, 3'd0, 3'd1, 3'd1, 3'd0, 3'd1};
			6'b000_010: shape = {3'd1, 3'd0, 3'd2, 3'd0, 3'd1, 3'd1};
			6'b000_011: shape = {3'd1, 3'd1, 3'd2, 3'd0, 3'd2, 3'd1};
			6'b000_100: shape = {3'd0, 3'd1, 3'd1, 3'd1, 3'd0, 3'd2};
			6'b000_101: shape = {3'd1, 3'd1, 3'd1, 3'd2, 3'd0, 3'd2};
			6'b000_110: shape = {3'd1, 3'd1, 3'd2, 3'd1, 3'd2, 3'd2};
			6'b000_111: shape = {3'd1, 3'd1, 3'd2, 3'd2, 3'd1, 3'd2};
			// coarse 4x4 patch, unsplit segments
			6'b100_000: shape = {3'd0, 3'd0, 3'd2, 3'd0, 3'd2, 3'd2};
			6'b100_001: shape = {3'd0, 3'd0, 3'd2, 3'd2, 3'd0, 3'd2};
			6'b100_010: shape = {3'd2, 3'd0, 3'd4, 3'd0, 3'd2, 3'd2};
			6'b100_011: shape = {3'd2, 3'd2, 3'd4, 3'd0, 3'd4, 3'd2};
			6'b100_100: shape = {3'd0, 3'd2, 3'd2, 3'd2, 3'd0, 3'd4};
			6'b100_101: shape = {3'd2, 3'd2, 3'd2, 3'd4, 3'd0, 3'd4};
			6'b100_110: shape = {3'd2, 3'd2, 3'd4, 3'd2, 3'd4, 3'd4};
			6'b100_111: shape = {3'd2, 3'd2, 3'd4, 3'd4, 3'd2, 3'd4};
			// coarse, first half of a stitched segment
			6'b110_000: shape = {3'd0, 3'd0, 3'd1, 3'd0, 3'd2, 3'd2};
			6'b110_001: shape = {3'd0, 3'd0, 3'd2, 3'd2, 3'd0, 3'd1};
			6'b110_010: shape = {3'd3, 3'd0, 3'd4, 3'd0, 3'd2, 3'd2};
			6'b110_011: shape = {3'd2, 3'd2, 3'd4, 3'd0, 3'd4, 3'd1};
			6'b110_100: shape = {3'd0, 3'd2, 3'd2, 3'd2, 3'd0, 3'd3};
			6'b110_101: shape = {3'd2, 3'd2, 3'd2, 3'd4, 3'd1, 3'd4};
			6'b110_110: shape = {3'd2, 3'd2, 3'd4, 3'd2, 3'd4, 3'd3};
			6'b110_111: shape = {3'd2, 3'd2, 3'd4, 3'd4, 3'd3, 3'd4};
			// coarse, second half of a stitched segment
			6'b111_000: shape = {3'd1, 3'd0, 3'd2, 3'd0, 3'd2, 3'd2};
			6'b111_001: shape = {3'd0, 3'd1, 3'd2, 3'd2, 3'd0, 3'd2};
			6'b111_010: shape = {3'd2, 3'd0, 3'd3, 3'd0, 3'd2, 3'd2};
			6'b111_011: shape = {3'd2, 3'd2, 3'd4, 3'd1, 3'd4, 3'd2};
			6'b111_100: shape = {3'd0, 3'd3, 3'd2, 3'd2, 3'd0, 3'd4};
			6'b111_101: shape = {3'd2, 3'd2, 3'd1, 3'd4, 3'd0, 3'd4};
			6'b111_110: shape = {3'd2, 3'd2, 3'd4, 3'd3, 3'd4, 3'd4};
			6'b111_111: shape = {3'd2, 3'd2, 3'd3, 3'd4, 3'd2, 3'd4};
			default:    shape = '0;
		endcase
		return shape;
	endfunction

endpackage

`default_nettype wire

### rtl/tgti_front.sv
// ----------------------------------------------------------------------------
// tgti_front: patch classifier
// Accepts a patch request, works out its origin, range and border flags and
// the base vertex index, and hands a descriptor to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module tgti_front
	import tgti_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,      // patch_col[6:0], patch_row[13:7], zero pad
	input  wire logic        s_tuser,      // req_type
	input  wire logic [7:0]  grid_width,
	input  wire logic [7:0]  grid_height,
	output logic             desc_valid,
	input  wire logic        desc_ready,
	output patch_desc_t      desc
);

	logic             v_s1;
	patch_desc_t      desc_s1;
	patch_desc_t      desc_new;
	logic [6:0]       col;
	logic [6:0]       row;
	logic [ORG_W-1:0] org_c;
	logic [ORG_W-1:0] org_r;
	logic [16:0]      row_prod;

	// Classify the incoming patch
	always_comb begin
		col   = s_tdata[6:0];
		row   = s_tdata[13:7];
		org_c = (s_tuser == REQ_COARSE) ? {col, 2'b00} : {1'b0, col, 1'b0};
		org_r = (s_tuser == REQ_COARSE) ? {row, 2'b00} : {1'b0, row, 1'b0};
		row_prod = 17'(org_r) * 17'(grid_width);
		desc_new.coarse   = (s_tuser == REQ_COARSE);
		desc_new.in_range = (({1'b0, org_c} + 10'd2) < {2'b00, grid_width}) &&
			(({1'b0, org_r} + 10'd2) < {2'b00, grid_height});
		desc_new.top      = (row == 7'd0);
		desc_new.left     = (col == 7'd0);
		desc_new.right    = (({1'b0, org_c} + 10'd6) >= {2'b00, grid_width});
		desc_new.bottom   = (({1'b0, org_r} + 10'd6) >= {2'b00, grid_height});
		desc_new.base     = IDX_W'(row_prod) + IDX_W'(org_c);
	end

	assign s_tready   = !v_s1 || desc_ready;
	assign desc_valid = v_s1;
	assign desc       = desc_s1;

	// Hold the classified patch until the queue takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			desc_s1 <= desc_new;
		end
	end

endmodule

`default_nettype wire

### rtl/tgti_fifo.sv
// ----------------------------------------------------------------------------
// tgti_fifo: patch descriptor queue
// Short first-in first-out queue that decouples the classifier from the
// triangle sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module tgti_fifo
	import tgti_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push_valid,
	output logic       push_ready,
	input  wire patch_desc_t push_data,
	output logic       pop_valid,
	input  wire logic  pop_ready,
	output patch_desc_t pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	patch_desc_t      mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             push;
	logic             pop;

	assign push_ready = (cnt_q != CNT_W'(DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem[rd_ptr_q];

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Store the pushed beat
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

### rtl/tgti_back.sv
// ----------------------------------------------------------------------------
// tgti_back: triangle sequencer
// Steps through the triangle segments of one queued patch, one triangle a
// cycle while the output is not stalled, and drives the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tgti_back
	import tgti_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [7:0]  grid_width,
	input  wire logic        desc_valid,
	output logic             desc_ready,
	input  wire patch_desc_t desc,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata,      // vert_a[15:0], vert_b[31:16], vert_c[47:32]
	output logic             m_tuser,      // in_range
	output logic             m_tlast       // last_tri
);

	logic        busy_q;
	patch_desc_t desc_q;
	logic [2:0]  seg_q;
	logic        sub_q;
	logic        m_tvalid_q;
	logic [47:0] m_tdata_q;
	logic        m_tuser_q;
	logic        m_tlast_q;

	logic        out_ready;
	logic        emit;
	logic        pop;
	logic        split;
	logic        last;
	tri_t        shape;
	logic [47:0] tri_data;
	logic [IDX_W-1:0] va_idx;
	logic [IDX_W-1:0] vb_idx;
	logic [IDX_W-1:0] vc_idx;

	// Vertex index: base plus row offset plus column offset
	function automatic logic [IDX_W-1:0] vtx_index(input logic [IDX_W-1:0] base,
		input logic [7:0] w, input logic [2:0] dc, input logic [2:0] dr);
		logic [IDX_W-1:0] wx;
		logic [IDX_W-1:0] row_off;
		wx = IDX_W'(w);
		unique case (dr)
			3'd0:    row_off = '0;
			3'd1:    row_off = wx;
			3'd2:    row_off = wx << 1;
			3'd3:    row_off = (wx << 1) + wx;
			3'd4:    row_off = wx << 2;
			default: row_off = '0;
		endcase
		return base + row_off + IDX_W'(dc);
	endfunction

	// Pick the stitch flag of the current segment and build its triangle
	always_comb begin
		unique case (seg_q)
			3'd0, 3'd2: split = desc_q.top;
			3'd1, 3'd4: split = desc_q.left;
			3'd3, 3'd6: split = desc_q.right;
			3'd5, 3'd7: split = desc_q.bottom;
			default:    split = 1'b0;
		endcase
		split = split && desc_q.coarse;
		shape = tri_shape(desc_q.coarse, seg_q, split, sub_q);
		last  = !desc_q.in_range || ((seg_q == SEG_LAST) && (!split || sub_q));
		va_idx = vtx_index(desc_q.base, grid_width, shape.ac, shape.ar);
		vb_idx = vtx_index(desc_q.base, grid_width, shape.bc, shape.br);
		vc_idx = vtx_index(desc_q.base, grid_width, shape.cc, shape.cr);
		if (desc_q.in_range) begin
			tri_data = {vc_idx[15:0], vb_idx[15:0], va_idx[15:0]};
		end else begin
			tri_data = '0;
		end
	end

	assign out_ready  = !m_tvalid_q || m_tready;
	assign emit       = busy_q && out_ready;
	assign desc_ready = !busy_q || (emit && last);
	assign pop        = desc_valid && desc_ready;

	// Load a patch and step through its segments
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			seg_q  <= '0;
			sub_q  <= 1'b0;
		end else if (pop) begin
			busy_q <= 1'b1;
			seg_q  <= '0;
			sub_q  <= 1'b0;
		end else if (emit && last) begin
			busy_q <= 1'b0;
			seg_q  <= '0;
			sub_q  <= 1'b0;
		end else if (emit) begin
			if (split && !sub_q) begin
				sub_q <= 1'b1;
			end else begin
				seg_q <= seg_q + 1'b1;
				sub_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			desc_q <= desc;
		end
	end

	// Output register: take a new beat whenever the old one leaves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (emit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			m_tdata_q <= tri_data;
			m_tuser_q <= desc_q.in_range;
			m_tlast_q <= last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

	// An out-of-range patch gives a single, final beat
	a_oor_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && !m_tuser_q) |-> m_tlast_q)
		else $error("out-of-range beat without last");

	// A fine patch never takes the second half of a segment
	a_fine_nosplit: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !desc_q.coarse) |-> !sub_q)
		else $error("fine patch in split half");

	// The sequencer rests at the first segment when idle
	a_idle_home: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (seg_q == 3'd0) && !sub_q)
		else $error("idle sequencer off its first segment");

	// After the last triangle the sequencer goes idle or starts a new patch
	a_last_reload: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && last && !desc_valid) |=> !busy_q)
		else $error("sequencer stayed busy after last triangle");

endmodule

`default_nettype wire

### rtl/terrain_grid_triangle_indexer.sv
// ----------------------------------------------------------------------------
// terrain_grid_triangle_indexer: patch to triangle index generator
// Turns a fine or coarse patch request of a row-major vertex grid into its
// triangles as three vertex indices each, stitching coarse borders.
// ----------------------------------------------------------------------------
//
//  channel  | signals                           | beat
//  ---------+-----------------------------------+--------------------------------
//  s        | s_tvalid s_tready s_tdata s_tuser | one patch request
//  m        | m_tvalid m_tready m_tdata m_tuser | one triangle (m_tlast on final)
//           | m_tlast                           |
//  cfg      | cfg_valid cfg_ready cfg_index     | one grid register write
//           | cfg_data                          |
//
//  A patch inside the grid gives 8 triangles (fine, or coarse with no
//  stitched border) up to 16 (coarse patch stitched on all four borders)
//  from the triangle sequencer, which gives one triangle a cycle while the
//  output is not stalled; a patch outside the grid gives a single beat.
//  Requests are taken one a cycle into a classifier stage and a queue of
//  QUEUE_DEPTH patches, so they stall only when the queue is full.
//  A request passes the classifier register, the queue, the patch register and the output register.
//  Reset sets both grid registers to 65; cfg_ready stays high.
//
`default_nettype none

module terrain_grid_triangle_indexer
	import tgti_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [15:0]          s_tdata,    // patch_col[6:0], patch_row[13:7], zero pad
	input  wire logic                 s_tuser,    // req_type
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [47:0]               m_tdata,    // vert_a[15:0], vert_b[31:16], vert_c[47:32]
	output logic                      m_tuser,    // in_range
	output logic                      m_tlast,    // last_tri
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [7:0]           cfg_data
);

	logic [7:0]  grid_width_q;
	logic [7:0]  grid_height_q;
	logic        front_valid;
	logic        front_ready;
	patch_desc_t front_desc;
	logic        back_valid;
	logic        back_ready;
	patch_desc_t back_desc;

	assign cfg_ready = 1'b1;

	// Grid size registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= 8'd65;
			grid_height_q <= 8'd65;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_GRID_WIDTH) begin
				grid_width_q <= cfg_data;
			end else if (cfg_index == REG_GRID_HEIGHT) begin
				grid_height_q <= cfg_data;
			end
		end
	end

	tgti_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.grid_width  (grid_width_q),
		.grid_height (grid_height_q),
		.desc_valid  (front_valid),
		.desc_ready  (front_ready),
		.desc        (front_desc)
	);

	tgti_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_data  (front_desc),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready),
		.pop_data   (back_desc)
	);

	tgti_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.grid_width (grid_width_q),
		.desc_valid (back_valid),
		.desc_ready (back_ready),
		.desc       (back_desc),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

endmodule

`default_nettype wire

### bench/terrain_grid_triangle_indexer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// terrain_grid_triangle_indexer_tb: self-checking bench of the triangle indexer
// Feeds fine and coarse patch requests over several grid sizes. Covers
// interior, border-stitched, corner and out-of-grid patches, with random
// bursts on the request side and random backpressure on the triangle side.
// Each accepted request is expanded into its triangle list by a local
// predictor and every triangle beat is checked in order against it.
// ----------------------------------------------------------------------------

module terrain_grid_triangle_indexer_tb;

	localparam int IDLE_LIMIT    = 3000;
	localparam int SETTLE_CYCLES = 20;
	localparam int HOLD_AT       = 60;
	localparam int HOLD_CYCLES   = 300;

	typedef struct {
		logic       coarse;
		logic [6:0] col;
		logic [6:0] row;
	} patch_req_t;

	typedef struct {
		logic [15:0] va;
		logic [15:0] vb;
		logic [15:0] vc;
		logic        in_range;
		logic        last;
	} facet_t;

	typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HEAVY} rx_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [tgti_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [7:0]  cfg_data = '0;

	// Local copy of the grid registers
	int grid_w = 65;
	int grid_h = 65;

	patch_req_t patch_pending_q[$];
	facet_t     facet_expect_q[$];

	int patches_taken = 0;
	int facets_seen = 0;
	int error_count = 0;
	int cfg_writes = 0;
	int grid_sizes = 1;
	int idle_cycles = 0;

	// Sender burst state
	int burst_left = 4;
	int gap_left = 0;

	// Receiver stall state
	rx_mode_t rx_mode = RX_OPEN;
	int       mode_left = 0;
	int       hold_left = 0;
	bit       hold_done = 1'b0;

	terrain_grid_triangle_indexer DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),    // patch_col[6:0], patch_row[13:7], zero pad
		.s_tuser   (s_tuser),    // req_type
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),    // vert_a[15:0], vert_b[31:16], vert_c[47:32]
		.m_tuser   (m_tuser),    // in_range
		.m_tlast   (m_tlast),    // last_tri
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// Row-major vertex index, kept to the 16-bit output field
	function automatic logic [15:0] vertex_index(input int oc, input int orw,
		input int dc, input int dr);
		int unsigned v;
		v = (orw + dr) * grid_w + (oc + dc);
		return v[15:0];
	endfunction

	function automatic void push_facet(input int oc, input int orw,
		input int ac, input int ar, input int bc, input int br, input int cc, input int cr);
		facet_t f;
		f.va = vertex_index(oc, orw, ac, ar);
		f.vb = vertex_index(oc, orw, bc, br);
		f.vc = vertex_index(oc, orw, cc, cr);
		f.in_range = 1'b1;
		f.last = 1'b0;
		facet_expect_q = {facet_expect_q, f};
	endfunction

	// Expand one patch request into its expected triangle list
	function automatic void predict_patch_facets(input patch_req_t p);
		facet_t miss;
		int     step;
		int     oc;
		int     orw;
		bit     top;
		bit     left;
		bit     right;
		bit     bottom;
		step = (p.coarse == tgti_pkg::REQ_COARSE) ? 4 : 2;
		oc = p.col * step;
		orw = p.row * step;
		if (oc + 2 >= grid_w || orw + 2 >= grid_h) begin
			miss.va = '0;
			miss.vb = '0;
			miss.vc = '0;
			miss.in_range = 1'b0;
			miss.last = 1'b1;
			facet_expect_q = {facet_expect_q, miss};
			return;
		end
		if (p.coarse == tgti_pkg::REQ_FINE) begin
			push_facet(oc, orw, 0, 0, 1, 0, 1, 1);
			push_facet(oc, orw, 0, 0, 1, 1, 0, 1);
			push_facet(oc, orw, 1, 0, 2, 0, 1, 1);
			push_facet(oc, orw, 1, 1, 2, 0, 2, 1);
			push_facet(oc, orw, 0, 1, 1, 1, 0, 2);
			push_facet(oc, orw, 1, 1, 1, 2, 0, 2);
			push_facet(oc, orw, 1, 1, 2, 1, 2, 2);
			push_facet(oc, orw, 1, 1, 2, 2, 1, 2);
		end else begin
			top = (orw == 0);
			left = (oc == 0);
			right = (oc + 6 >= grid_w);
			bottom = (orw + 6 >= grid_h);
			// split border segments toward the finer neighbour
			if (top) begin
				push_facet(oc, orw, 0, 0, 1, 0, 2, 2);
				push_facet(oc, orw, 1, 0, 2, 0, 2, 2);
			end else
				push_facet(oc, orw, 0, 0, 2, 0, 2, 2);
			if (left) begin
				push_facet(oc, orw, 0, 0, 2, 2, 0, 1);
				push_facet(oc, orw, 0, 1, 2, 2, 0, 2);
			end else
				push_facet(oc, orw, 0, 0, 2, 2, 0, 2);
			if (top) begin
				push_facet(oc, orw, 3, 0, 4, 0, 2, 2);
				push_facet(oc, orw, 2, 0, 3, 0, 2, 2);
			end else
				push_facet(oc, orw, 2, 0, 4, 0, 2, 2);
			if (right) begin
				push_facet(oc, orw, 2, 2, 4, 0, 4, 1);
				push_facet(oc, orw, 2, 2, 4, 1, 4, 2);
			end else
				push_facet(oc, orw, 2, 2, 4, 0, 4, 2);
			if (left) begin
				push_facet(oc, orw, 0, 2, 2, 2, 0, 3);
				push_facet(oc, orw, 0, 3, 2, 2, 0, 4);
			end else
				push_facet(oc, orw, 0, 2, 2, 2, 0, 4);
			if (bottom) begin
				push_facet(oc, orw, 2, 2, 2, 4, 1, 4);
				push_facet(oc, orw, 2, 2, 1, 4, 0, 4);
			end else
				push_facet(oc, orw, 2, 2, 2, 4, 0, 4);
			if (right) begin
				push_facet(oc, orw, 2, 2, 4, 2, 4, 3);
				push_facet(oc, orw, 2, 2, 4, 3, 4, 4);
			end else
				push_facet(oc, orw, 2, 2, 4, 2, 4, 4);
			if (bottom) begin
				push_facet(oc, orw, 2, 2, 4, 4, 3, 4);
				push_facet(oc, orw, 2, 2, 3, 4, 2, 4);
			end else
				push_facet(oc, orw, 2, 2, 4, 4, 2, 4);
		end
		facet_expect_q[facet_expect_q.size() - 1].last = 1'b1;
	endfunction

	function automatic void queue_patch(input logic coarse, input int col, input int row);
		patch_req_t p;
		p.coarse = coarse;
		p.col = col[6:0];
		p.row = row[6:0];
		patch_pending_q = {patch_pending_q, p};
	endfunction

	// Mostly patches inside the current grid, edges favored, some anywhere
	function automatic void queue_random_patch();
		logic coarse;
		int   step;
		int   max_col;
		int   max_row;
		int   col;
		int   row;
		coarse = $urandom_range(0, 1);
		step = (coarse == tgti_pkg::REQ_COARSE) ? 4 : 2;
		max_col = (grid_w - 3) / step;
		max_row = (grid_h - 3) / step;
		if (max_col > 127)
			max_col = 127;
		if (max_row > 127)
			max_row = 127;
		if ($urandom_range(0, 4) == 0) begin
			col = $urandom_range(0, 127);
			row = $urandom_range(0, 127);
		end else begin
			case ($urandom_range(0, 3))
				0: col = 0;
				1: col = max_col;
				default: col = $urandom_range(0, max_col);
			endcase
			case ($urandom_range(0, 3))
				0: row = 0;
				1: row = max_row;
				default: row = $urandom_range(0, max_row);
			endcase
		end
		queue_patch(coarse, col, row);
	endfunction

	task automatic check_field(input string name, input int exp_val, input int act_val);
		if (exp_val != act_val) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_val, act_val);
			error_count++;
		end
	endtask

	task automatic check_facet();
		facet_t f;
		if (facet_expect_q.size() == 0) begin
			$display("%0t: unexpected triangle beat, expected none, got %h/%b/%b",
				$time, m_tdata, m_tuser, m_tlast);
			error_count++;
		end else begin
			f = facet_expect_q.pop_front();
			check_field("vert_a", f.va, m_tdata[15:0]);
			check_field("vert_b", f.vb, m_tdata[31:16]);
			check_field("vert_c", f.vc, m_tdata[47:32]);
			check_field("in_range", f.in_range, m_tuser);
			check_field("last_tri", f.last, m_tlast);
		end
		facets_seen++;
	endtask

	task automatic write_grid_reg(input logic [tgti_pkg::CFG_IDX_W-1:0] idx, input int value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[7:0];
		do
			@(posedge clk);
		while (!(cfg_valid && cfg_ready));
		if (idx == tgti_pkg::REG_GRID_WIDTH)
			grid_w = value;
		else
			grid_h = value;
		cfg_writes++;
		cfg_valid <= 1'b0;
	endtask

	task automatic set_grid(input int width, input int height);
		write_grid_reg(tgti_pkg::REG_GRID_WIDTH, width);
		write_grid_reg(tgti_pkg::REG_GRID_HEIGHT, height);
		grid_sizes++;
	endtask

	// Let the pending requests run out and the pipeline empty
	task automatic drain_patches();
		while (patch_pending_q.size() != 0 || s_tvalid || facet_expect_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic queue_random_set(input int count);
		@(negedge clk);
		repeat (count) queue_random_patch();
	endtask

	// Request sender: bursts of beats with random gaps
	always @(posedge clk) begin : sender
		patch_req_t cur;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				cur = patch_pending_q.pop_front();
				predict_patch_facets(cur);
				patches_taken <= patches_taken + 1;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 12);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				end
			end
			if (gap_left > 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (patch_pending_q.size() != 0) begin
				s_tvalid <= 1'b1;
				s_tdata <= {2'b00, patch_pending_q[0].row, patch_pending_q[0].col};
				s_tuser <= patch_pending_q[0].coarse;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Triangle receiver: check each beat, stall on a changing pattern
	always @(posedge clk) begin : receiver
		logic ready_next;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready)
				check_facet();
			if (hold_left > 0) begin
				hold_left--;
				ready_next = 1'b0;
			end else if (!hold_done && patches_taken >= HOLD_AT) begin
				// long hold-off so the request side backs up
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
				ready_next = 1'b0;
			end else begin
				if (mode_left == 0) begin
					rx_mode = rx_mode_t'($urandom_range(0, 2));
					mode_left = $urandom_range(20, 120);
				end else
					mode_left--;
				case (rx_mode)
					RX_OPEN:  ready_next = 1'b1;
					RX_LIGHT: ready_next = ($urandom_range(0, 3) != 0);
					default:  ready_next = ($urandom_range(0, 1) != 0);
				endcase
			end
			m_tready <= ready_next;
		end
	end

	// Watchdog on cycles with no beat on any channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: timeout, no beat for %0d cycles", $time, idle_cycles);
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset grid 65x65: interior, every border, corners, out of grid
		@(negedge clk);
		queue_patch(tgti_pkg::REQ_FINE, 0, 0);
		queue_patch(tgti_pkg::REQ_FINE, 31, 31);
		queue_patch(tgti_pkg::REQ_FINE, 32, 0);
		queue_patch(tgti_pkg::REQ_FINE, 0, 32);
		queue_patch(tgti_pkg::REQ_FINE, 127, 127);
		queue_patch(tgti_pkg::REQ_COARSE, 0, 0);
		queue_patch(tgti_pkg::REQ_COARSE, 15, 0);
		queue_patch(tgti_pkg::REQ_COARSE, 0, 15);
		queue_patch(tgti_pkg::REQ_COARSE, 15, 15);
		queue_patch(tgti_pkg::REQ_COARSE, 7, 7);
		queue_patch(tgti_pkg::REQ_COARSE, 3, 0);
		queue_patch(tgti_pkg::REQ_COARSE, 0, 3);
		queue_patch(tgti_pkg::REQ_COARSE, 16, 3);
		queue_patch(tgti_pkg::REQ_COARSE, 127, 127);
		queue_random_set(40);
		drain_patches();

		// Smallest grid: one coarse patch stitched on all four sides
		set_grid(5, 5);
		@(negedge clk);
		queue_patch(tgti_pkg::REQ_COARSE, 0, 0);
		queue_patch(tgti_pkg::REQ_FINE, 0, 0);
		queue_patch(tgti_pkg::REQ_FINE, 1, 1);
		queue_patch(tgti_pkg::REQ_FINE, 2, 1);
		queue_patch(tgti_pkg::REQ_COARSE, 1, 0);
		queue_random_set(30);
		drain_patches();

		// Largest grid: highest indices and wide patch columns
		set_grid(253, 253);
		@(negedge clk);
		queue_patch(tgti_pkg::REQ_COARSE, 62, 62);
		queue_patch(tgti_pkg::REQ_COARSE, 0, 62);
		queue_patch(tgti_pkg::REQ_FINE, 125, 125);
		queue_patch(tgti_pkg::REQ_FINE, 64, 64);
		queue_patch(tgti_pkg::REQ_FINE, 126, 0);
		queue_patch(tgti_pkg::REQ_COARSE, 63, 0);
		queue_random_set(45);
		drain_patches();

		// Lopsided extremes, then random sizes, the last with a 4k+1 width
		set_grid(253, 5);
		queue_random_set(32);
		drain_patches();
		set_grid(5, 253);
		queue_random_set(32);
		drain_patches();
		set_grid($urandom_range(5, 253), $urandom_range(5, 253));
		queue_random_set(32);
		drain_patches();
		set_grid(4 * $urandom_range(1, 63) + 1, 2 * $urandom_range(2, 126) + 1);
		queue_random_set(32);
		drain_patches();

		if (facet_expect_q.size() != 0) begin
			$display("%0t: %0d triangles still expected, got none", $time,
				facet_expect_q.size());
			error_count += facet_expect_q.size();
		end
		$display("Ran %0d patch requests giving %0d triangles over %0d grid sizes,",
			patches_taken, facets_seen, grid_sizes);
		$display("with %0d register writes and %0d mismatches", cfg_writes, error_count);
		if (error_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
